/* rtl/sqlf_pkg.sv */
// Shared constants, operation codes and control types of the store queue.
`default_nettype none

package sqlf_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_FLAG   = 3'd2;
    localparam logic [OP_W-1:0] OP_APPLY  = 3'd3;
    localparam logic [OP_W-1:0] OP_RETIRE = 3'd4;

    typedef logic [IDX_W-1:0]   slot_idx_t;
    typedef logic [ENTRIES-1:0] slot_vec_t;

    // controller -> datapath
    typedef struct packed {
        logic start;   // latch the incoming word, reset the scan
        logic scan;    // read one slot and advance the scan index
        logic finish;  // commit the operation and load the result register
    } sqlf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic needs_scan;  // incoming operation walks the slots
        logic scan_last;   // scan index sits on the last slot
    } sqlf_status_t;

endpackage

`default_nettype wire

/* rtl/sqlf_ifs.sv */
// Valid/ready channel interfaces for the request and result words.
`default_nettype none

interface sqlf_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [31:0]        inst_tag;
    logic [31:0]        mem_address;
    logic signed [31:0] store_data;

    modport source (output valid, operation, inst_tag, mem_address, store_data,
                    input ready);
    modport sink   (input valid, operation, inst_tag, mem_address, store_data,
                    output ready);
endinterface

interface sqlf_rsp_if;
    logic               valid;
    logic               ready;
    logic               older_store_hit;
    logic               forward_found;
    logic signed [31:0] forward_data;
    logic               add_accepted;
    logic               has_vacancy;
    logic               queue_busy;
    logic               retire_valid;
    logic [31:0]        retire_address;
    logic signed [31:0] retire_data;
    logic [31:0]        retire_tag;

    modport source (output valid, older_store_hit, forward_found, forward_data,
                    add_accepted, has_vacancy, queue_busy, retire_valid,
                    retire_address, retire_data, retire_tag,
                    input ready);
    modport sink   (input valid, older_store_hit, forward_found, forward_data,
                    add_accepted, has_vacancy, queue_busy, retire_valid,
                    retire_address, retire_data, retire_tag,
                    output ready);
endinterface

`default_nettype wire

/* rtl/sqlf_ctrl.sv */
// Control state machine of the store queue: sequences scan and commit.
`default_nettype none

module sqlf_ctrl
    import sqlf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  sqlf_status_t status,
    output sqlf_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = status.needs_scan ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* rtl/sqlf_dpath.sv */
// Datapath of the store queue: slot storage, scan compare and result register.
`default_nettype none

module sqlf_dpath
    import sqlf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  sqlf_cmd_t                cmd,
    output sqlf_status_t             status,
    input  logic [OP_W-1:0]          operation,
    input  logic [WORD_W-1:0]        inst_tag,
    input  logic [WORD_W-1:0]        mem_address,
    input  logic signed [WORD_W-1:0] store_data,
    output logic                     older_store_hit,
    output logic                     forward_found,
    output logic signed [WORD_W-1:0] forward_data,
    output logic                     add_accepted,
    output logic                     has_vacancy,
    output logic                     queue_busy,
    output logic                     retire_valid,
    output logic [WORD_W-1:0]        retire_address,
    output logic signed [WORD_W-1:0] retire_data,
    output logic [WORD_W-1:0]        retire_tag
);

    // slot payload memory, one write port, one registered read port
    logic [WORD_W-1:0]        mem_tag  [ENTRIES];
    logic [WORD_W-1:0]        mem_addr [ENTRIES];
    logic signed [WORD_W-1:0] mem_data [ENTRIES];

    // control state
    slot_vec_t valid_reg, valid_next;
    slot_vec_t completed_reg, completed_next;
    slot_vec_t pending_reg, pending_next;
    slot_idx_t scan_idx_reg, scan_idx_next;
    logic      rd_vld_reg, rd_vld_next;
    logic      hit_reg, hit_next;

    // payload
    logic [OP_W-1:0]          op_reg, op_next;
    logic [WORD_W-1:0]        tag_reg, tag_next;
    logic [WORD_W-1:0]        addr_reg, addr_next;
    logic signed [WORD_W-1:0] data_reg, data_next;
    slot_idx_t                rd_idx_reg, rd_idx_next;
    logic [WORD_W-1:0]        rd_tag_reg;
    logic [WORD_W-1:0]        rd_addr_reg;
    logic signed [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0]        best_tag_reg, best_tag_next;
    logic [WORD_W-1:0]        best_addr_reg, best_addr_next;
    logic signed [WORD_W-1:0] best_data_reg, best_data_next;
    slot_idx_t                best_idx_reg, best_idx_next;

    // result register
    logic                     o_hit_reg, o_hit_next;
    logic signed [WORD_W-1:0] o_fwd_reg, o_fwd_next;
    logic                     o_add_reg, o_add_next;
    logic                     o_vac_reg, o_vac_next;
    logic                     o_busy_reg, o_busy_next;
    logic                     o_ret_reg, o_ret_next;
    logic [WORD_W-1:0]        o_raddr_reg, o_raddr_next;
    logic signed [WORD_W-1:0] o_rdata_reg, o_rdata_next;
    logic [WORD_W-1:0]        o_rtag_reg, o_rtag_next;

    slot_idx_t free_idx;
    logic      free_any;
    logic      add_wr;

    assign status.needs_scan = (operation == OP_LOOKUP) || (operation == OP_FLAG) ||
                               (operation == OP_RETIRE);
    assign status.scan_last  = (scan_idx_reg == slot_idx_t'(ENTRIES - 1));

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = slot_idx_t'(i);
            end
        end
    end
    assign free_any = ~&valid_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        completed_next = completed_reg;
        pending_next   = pending_reg;
        scan_idx_next  = scan_idx_reg;
        rd_vld_next    = cmd.scan;
        rd_idx_next    = cmd.scan ? scan_idx_reg : rd_idx_reg;
        hit_next       = hit_reg;
        op_next        = op_reg;
        tag_next       = tag_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        best_tag_next  = best_tag_reg;
        best_addr_next = best_addr_reg;
        best_data_next = best_data_reg;
        best_idx_next  = best_idx_reg;
        o_hit_next     = o_hit_reg;
        o_fwd_next     = o_fwd_reg;
        o_add_next     = o_add_reg;
        o_vac_next     = o_vac_reg;
        o_busy_next    = o_busy_reg;
        o_ret_next     = o_ret_reg;
        o_raddr_next   = o_raddr_reg;
        o_rdata_next   = o_rdata_reg;
        o_rtag_next    = o_rtag_reg;
        add_wr         = 1'b0;

        if (cmd.start)
        begin
            op_next       = operation;
            tag_next      = inst_tag;
            addr_next     = mem_address;
            data_next     = store_data;
            scan_idx_next = '0;
            hit_next      = 1'b0;
        end

        if (cmd.scan)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        // compare stage: one slot per cycle, in the cycle after the read
        if (rd_vld_reg && valid_reg[rd_idx_reg])
        begin
            unique case (op_reg)
                OP_LOOKUP:
                begin
                    if (rd_addr_reg == addr_reg && rd_tag_reg < tag_reg)
                    begin
                        if (!hit_reg || rd_tag_reg > best_tag_reg)
                        begin
                            best_tag_next  = rd_tag_reg;
                            best_data_next = rd_data_reg;
                        end
                        hit_next = 1'b1;
                    end
                end
                OP_FLAG:
                begin
                    if (rd_tag_reg == tag_reg)
                    begin
                        pending_next[rd_idx_reg] = 1'b1;
                    end
                end
                OP_RETIRE:
                begin
                    if (!hit_reg || rd_tag_reg < best_tag_reg)
                    begin
                        best_tag_next  = rd_tag_reg;
                        best_addr_next = rd_addr_reg;
                        best_data_next = rd_data_reg;
                        best_idx_next  = rd_idx_reg;
                    end
                    hit_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.finish)
        begin
            o_hit_next   = 1'b0;
            o_fwd_next   = '1;
            o_add_next   = 1'b0;
            o_ret_next   = 1'b0;
            o_raddr_next = '0;
            o_rdata_next = '0;
            o_rtag_next  = '0;
            unique case (op_reg)
                OP_ADD:
                begin
                    if (free_any)
                    begin
                        valid_next[free_idx]     = 1'b1;
                        completed_next[free_idx] = 1'b0;
                        pending_next[free_idx]   = 1'b0;
                        add_wr                   = 1'b1;
                        o_add_next               = 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    o_hit_next = hit_reg;
                    o_fwd_next = hit_reg ? best_data_reg : '1;
                end
                OP_APPLY:
                begin
                    completed_next = completed_reg | (valid_reg & pending_reg);
                    pending_next   = pending_reg & ~valid_reg;
                end
                OP_RETIRE:
                begin
                    if (hit_reg && completed_reg[best_idx_reg])
                    begin
                        valid_next[best_idx_reg]     = 1'b0;
                        completed_next[best_idx_reg] = 1'b0;
                        pending_next[best_idx_reg]   = 1'b0;
                        o_ret_next                   = 1'b1;
                        o_raddr_next                 = best_addr_reg;
                        o_rdata_next                 = best_data_reg;
                        o_rtag_next                  = best_tag_reg;
                    end
                end
                default:
                begin
                end
            endcase
            o_vac_next  = ~&valid_next;
            o_busy_next = |valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_wr)
        begin
            mem_tag[free_idx]  <= tag_reg;
            mem_addr[free_idx] <= addr_reg;
            mem_data[free_idx] <= data_reg;
        end
        if (cmd.scan)
        begin
            rd_tag_reg  <= mem_tag[scan_idx_reg];
            rd_addr_reg <= mem_addr[scan_idx_reg];
            rd_data_reg <= mem_data[scan_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            completed_reg <= '0;
            pending_reg   <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            completed_reg <= completed_next;
            pending_reg   <= pending_next;
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= rd_vld_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tag_reg       <= tag_next;
        addr_reg      <= addr_next;
        data_reg      <= data_next;
        rd_idx_reg    <= rd_idx_next;
        best_tag_reg  <= best_tag_next;
        best_addr_reg <= best_addr_next;
        best_data_reg <= best_data_next;
        best_idx_reg  <= best_idx_next;
        o_hit_reg     <= o_hit_next;
        o_fwd_reg     <= o_fwd_next;
        o_add_reg     <= o_add_next;
        o_vac_reg     <= o_vac_next;
        o_busy_reg    <= o_busy_next;
        o_ret_reg     <= o_ret_next;
        o_raddr_reg   <= o_raddr_next;
        o_rdata_reg   <= o_rdata_next;
        o_rtag_reg    <= o_rtag_next;
    end

    assign older_store_hit = o_hit_reg;
    assign forward_found   = o_hit_reg;
    assign forward_data    = o_fwd_reg;
    assign add_accepted    = o_add_reg;
    assign has_vacancy     = o_vac_reg;
    assign queue_busy      = o_busy_reg;
    assign retire_valid    = o_ret_reg;
    assign retire_address  = o_raddr_reg;
    assign retire_data     = o_rdata_reg;
    assign retire_tag      = o_rtag_reg;

endmodule

`default_nettype wire

/* rtl/store_queue_load_forwarding.sv */
// Top level of the store queue with store-to-load forwarding.
//
//  channel | dir | handshake    | word
//  --------+-----+--------------+--------------------------------------------------
//  req     | in  | valid/ready  | operation, inst_tag, mem_address, store_data
//  rsp     | out | valid/ready  | hit/forward, add_accepted, vacancy/busy, retire
//
// Add, apply and unused codes go from the accept state straight to the commit. Lookup,
// flag and retire walk the slot memory one slot per cycle through its single read
// port, then pass a drain state before the commit.
// Reset clears all slot flags at once; no clearing pass is needed.
// A finished word sits in the result register; the next request word is accepted
// while it waits, and its commit stalls only until that register drains.
`default_nettype none

module store_queue_load_forwarding
    import sqlf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sqlf_req_if.sink  req,
    sqlf_rsp_if.source rsp
);

    sqlf_cmd_t    cmd;
    sqlf_status_t status;

    // sequencer: idle -> (scan -> drain) -> commit
    sqlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // slot storage, compare stage and result register
    sqlf_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .operation       (req.operation),
        .inst_tag        (req.inst_tag),
        .mem_address     (req.mem_address),
        .store_data      (req.store_data),
        .older_store_hit (rsp.older_store_hit),
        .forward_found   (rsp.forward_found),
        .forward_data    (rsp.forward_data),
        .add_accepted    (rsp.add_accepted),
        .has_vacancy     (rsp.has_vacancy),
        .queue_busy      (rsp.queue_busy),
        .retire_valid    (rsp.retire_valid),
        .retire_address  (rsp.retire_address),
        .retire_data     (rsp.retire_data),
        .retire_tag      (rsp.retire_tag)
    );

endmodule

`default_nettype wire

/* rtl/sqlf_checker.sv */
// Port-level assertions for the store queue, bound to the top level.
`default_nettype none

module sqlf_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               rsp_valid,
    input wire               rsp_ready,
    input wire               older_store_hit,
    input wire               forward_found,
    input wire signed [31:0] forward_data,
    input wire               add_accepted,
    input wire               has_vacancy,
    input wire               queue_busy,
    input wire               retire_valid
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    a_fwd_match: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> forward_found == older_store_hit)
        else $error("forward_found differs from older_store_hit");

    a_fwd_none: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !older_store_hit |-> forward_data == -32'sd1)
        else $error("forward_data not all ones without a hit");

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> has_vacancy || queue_busy)
        else $error("queue both empty and full");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && retire_valid |-> !add_accepted && !older_store_hit)
        else $error("retire reported together with another operation");

endmodule

bind store_queue_load_forwarding sqlf_checker u_sqlf_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .older_store_hit (rsp.older_store_hit),
    .forward_found   (rsp.forward_found),
    .forward_data    (rsp.forward_data),
    .add_accepted    (rsp.add_accepted),
    .has_vacancy     (rsp.has_vacancy),
    .queue_busy      (rsp.queue_busy),
    .retire_valid    (rsp.retire_valid)
);

`default_nettype wire
